@@ design/pdd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdd_pkg
// Shared types and constants of the palette delta decoder.
// ----------------------------------------------------------------------------
package pdd_pkg;

   localparam int BYTE_W  = 8;
   localparam int RGB_W   = 3 * BYTE_W;
   localparam int RUN_W   = 7;
   localparam int PEND_W  = 2 * BYTE_W;

   // command byte fields
   localparam logic [BYTE_W-1:0] CMD_SKIP_BIT = 8'h80;
   localparam logic [BYTE_W-1:0] CMD_COPY_BIT = 8'h40;
   localparam logic [BYTE_W-1:0] SKIP_MASK    = 8'h7F;
   localparam logic [BYTE_W-1:0] LEN_MASK     = 8'h3F;

   typedef logic [RGB_W-1:0] rgb_type;

   typedef enum logic [2:0] {
      PH_CMD  = 3'd0,
      PH_SRC  = 3'd1,
      PH_RED  = 3'd2,
      PH_GRN  = 3'd3,
      PH_BLU  = 3'd4,
      PH_FULL = 3'd5
   } phase_type;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_LOOKUP = 2'd1,
      ST_COPY   = 2'd2
   } state_type;

   // 6-bit color component scaled to 8 bits
   function automatic logic [BYTE_W-1:0] scale6(input logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] m;
      m = b & LEN_MASK;
      return {m[5:0], 2'b00};
   endfunction

endpackage

@@ design/pdd_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdd_req_if / pdd_rsp_if
// Valid/ready channels for stream bytes and lookup results.
// ----------------------------------------------------------------------------
interface pdd_req_if;
   logic                       valid;
   logic                       ready;
   logic                       mode;
   logic [pdd_pkg::BYTE_W-1:0] data_byte;
   logic                       chunk_end;

   modport source (output valid, output mode, output data_byte, output chunk_end,
                   input ready);
   modport sink   (input valid, input mode, input data_byte, input chunk_end,
                   output ready);
endinterface

interface pdd_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [pdd_pkg::BYTE_W-1:0] red;
   logic [pdd_pkg::BYTE_W-1:0] green;
   logic [pdd_pkg::BYTE_W-1:0] blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

@@ design/pdd_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdd_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module pdd_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH)-1:0]         wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic                             rd_en,
   input  logic [$clog2(DEPTH)-1:0]         rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/palette_delta_decoder_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palette_delta_decoder_core
// Palette store updated by a delta command stream, read by pixel lookups.
// ----------------------------------------------------------------------------
// req_chan carries one item per byte: mode 0 feeds the palette command parser
// (chunk_end marks the last byte of a chunk), mode 1 looks up a pixel index.
// rsp_chan returns one RGB item per lookup and nothing for stream bytes.
// Throughput: stream bytes are taken one per cycle while no lookup or copy
// is under way. A lookup is the palette RAM read, then the load of the
// output register, which waits while that register is full. A copy source
// byte holds the input until its run is done; the single RAM write port moves
// one entry per cycle, with the read of the next source overlapped and
// forwarded when it hits the entry just written.
// Reset clears the parser and the per-entry written bits, so the palette
// reads as the grayscale ramp again at once, with no clearing pass.
// A stalled receiver holds the output register while stream bytes are still
// taken; a new lookup then waits in its read stage and holds off the input
// until the output register frees.
// ----------------------------------------------------------------------------
module palette_delta_decoder_core #(
   parameter int PALETTE_ENTRIES = 256
) (
   input  logic      clock,
   input  logic      reset,
   pdd_req_if.sink   req_chan,
   pdd_rsp_if.source rsp_chan
);
   import pdd_pkg::*;

   localparam int AW = $clog2(PALETTE_ENTRIES);
   localparam int PW = $clog2(PALETTE_ENTRIES + 1);
   localparam int SW = ((PW > BYTE_W) ? PW : BYTE_W) + 1;
   localparam logic [PW-1:0] POS_END = PW'(PALETTE_ENTRIES);
   localparam logic [SW-1:0] SUM_END = SW'(PALETTE_ENTRIES);

   state_type              state_ff, state_in;
   phase_type              phase_ff, phase_in;
   logic [PW-1:0]          pos_ff, pos_in;
   logic [RUN_W-1:0]       run_ff, run_in;
   logic [BYTE_W-1:0]      src_ff, src_in;
   logic [PEND_W-1:0]      pend_ff, pend_in;
   logic                   last_ff, last_in;

   logic [BYTE_W-1:0]      rd_idx_ff, rd_idx_in;
   logic                   rd_oob_ff, rd_oob_in;
   logic                   rd_vld_ff, rd_vld_in;
   logic                   fwd_ff, fwd_in;
   rgb_type                fwd_data_ff, fwd_data_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   rgb_type                rsp_rgb_ff, rsp_rgb_in;
   logic [PALETTE_ENTRIES-1:0] written_ff;

   logic                   accept;
   logic                   out_free;
   logic                   copy_done;
   logic [PW-1:0]          pos_plus;
   logic [SW-1:0]          skip_sum;
   logic [BYTE_W-1:0]      src_next;
   logic [BYTE_W-1:0]      rd_byte;
   logic                   rd_en;
   logic                   wr_en;
   rgb_type                wr_data;
   rgb_type                ram_q;
   rgb_type                rd_word;
   logic [BYTE_W-1:0]      b;

   assign b         = req_chan.data_byte;
   assign accept    = req_chan.valid && req_chan.ready;
   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign pos_plus  = pos_ff + 1'b1;
   assign skip_sum  = SW'(pos_ff) + SW'(b & SKIP_MASK) + 1'b1;
   assign src_next  = src_ff + 1'b1;
   assign copy_done = (run_ff == RUN_W'(1)) || (pos_plus == POS_END);

   // unwritten entries read as the ramp, out-of-range indexes as zero
   always_comb begin
      if (rd_oob_ff) begin
         rd_word = '0;
      end else if (fwd_ff) begin
         rd_word = fwd_data_ff;
      end else if (rd_vld_ff) begin
         rd_word = ram_q;
      end else begin
         rd_word = {rd_idx_ff, rd_idx_ff, rd_idx_ff};
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_chan.mode) begin
               state_in = ST_LOOKUP;
            end else if (accept && phase_ff == PH_SRC) begin
               state_in = ST_COPY;
            end
         end
         ST_LOOKUP: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_COPY: begin
            if (copy_done) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      phase_in     = phase_ff;
      pos_in       = pos_ff;
      run_in       = run_ff;
      src_in       = src_ff;
      pend_in      = pend_ff;
      last_in      = last_ff;
      rd_en        = 1'b0;
      rd_byte      = b;
      fwd_in       = 1'b0;
      wr_en        = 1'b0;
      wr_data      = rd_word;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_rgb_in   = rsp_rgb_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_chan.mode) begin
               rd_en = 1'b1;
            end else if (accept) begin
               unique case (phase_ff)
                  PH_CMD: begin
                     if ((b & CMD_SKIP_BIT) != '0) begin
                        run_in = '0;
                        if (skip_sum >= SUM_END) begin
                           pos_in   = POS_END;
                           phase_in = PH_FULL;
                        end else begin
                           pos_in   = skip_sum[PW-1:0];
                           phase_in = PH_CMD;
                        end
                     end else begin
                        run_in   = RUN_W'(b & LEN_MASK) + 1'b1;
                        phase_in = ((b & CMD_COPY_BIT) != '0) ? PH_SRC : PH_RED;
                     end
                  end
                  PH_SRC: begin
                     src_in  = b;
                     rd_en   = 1'b1;
                     last_in = req_chan.chunk_end;
                  end
                  PH_RED: begin
                     pend_in  = {scale6(b), pend_ff[BYTE_W-1:0]};
                     phase_in = PH_GRN;
                  end
                  PH_GRN: begin
                     pend_in  = {pend_ff[PEND_W-1:BYTE_W], scale6(b)};
                     phase_in = PH_BLU;
                  end
                  PH_BLU: begin
                     wr_en   = 1'b1;
                     wr_data = {pend_ff, scale6(b)};
                     pos_in  = pos_plus;
                     run_in  = run_ff - 1'b1;
                     if (pos_plus == POS_END) begin
                        phase_in = PH_FULL;
                     end else if (run_ff == RUN_W'(1)) begin
                        phase_in = PH_CMD;
                     end else begin
                        phase_in = PH_RED;
                     end
                  end
                  default: ;
               endcase
               // chunk end after a copy source waits for the copy run
               if (req_chan.chunk_end && phase_ff != PH_SRC) begin
                  pos_in   = '0;
                  phase_in = PH_CMD;
                  run_in   = '0;
               end
            end
         end
         ST_LOOKUP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_rgb_in   = rd_word;
            end
         end
         ST_COPY: begin
            wr_en   = 1'b1;
            wr_data = rd_word;
            pos_in  = pos_plus;
            run_in  = run_ff - 1'b1;
            src_in  = src_next;
            if (copy_done) begin
               run_in = '0;
               if (last_ff) begin
                  pos_in   = '0;
                  phase_in = PH_CMD;
               end else if (pos_plus == POS_END) begin
                  phase_in = PH_FULL;
               end else begin
                  phase_in = PH_CMD;
               end
            end else begin
               rd_en   = 1'b1;
               rd_byte = src_next;
               // next source is the entry being written this cycle
               fwd_in  = (SW'(src_next) == SW'(pos_ff));
            end
         end
         default: ;
      endcase
   end

   assign rd_idx_in   = rd_byte;
   assign rd_oob_in   = SW'(rd_byte) >= SUM_END;
   assign rd_vld_in   = written_ff[rd_byte[AW-1:0]];
   assign fwd_data_in = wr_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_CMD;
         pos_ff       <= '0;
         run_ff       <= '0;
         src_ff       <= '0;
         pend_ff      <= '0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         written_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         pos_ff       <= pos_in;
         run_ff       <= run_in;
         src_ff       <= src_in;
         pend_ff      <= pend_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
         if (wr_en) begin
            written_ff[pos_ff[AW-1:0]] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_rgb_ff <= rsp_rgb_in;
      if (rd_en) begin
         rd_idx_ff   <= rd_idx_in;
         rd_oob_ff   <= rd_oob_in;
         rd_vld_ff   <= rd_vld_in;
         fwd_ff      <= fwd_in;
         fwd_data_ff <= fwd_data_in;
      end
   end

   pdd_ram #(
      .WIDTH (RGB_W),
      .DEPTH (PALETTE_ENTRIES)
   ) u_palette_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (pos_ff[AW-1:0]),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_byte[AW-1:0]),
      .rd_data (ram_q)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.red   = rsp_rgb_ff[RGB_W-1:2*BYTE_W];
   assign rsp_chan.green = rsp_rgb_ff[2*BYTE_W-1:BYTE_W];
   assign rsp_chan.blue  = rsp_rgb_ff[BYTE_W-1:0];

endmodule

@@ sim/tb_palette_delta_decoder_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_palette_delta_decoder_core
// Self-checking bench for the palette delta decoder core.
// ----------------------------------------------------------------------------
// Palette stream bytes and pixel lookups go in over the request channel. Each
// accepted item is also applied to a palette kept in the bench, and every
// lookup queues the RGB that entry should return. Results are compared in
// order, field by field. A short table of directed items comes first: reset
// ramp, skip, set, copy with wrap and overlap, chunk end cases and a full
// palette. Random chunks follow, mostly well formed, some cut short, with
// lookups mixed in. Both channels idle at random; the receiver also blocks
// once for a long stretch and the sender twice waits for all results.
// ----------------------------------------------------------------------------
module tb_palette_delta_decoder_core;
   import pdd_pkg::*;

   localparam int   PAL_ENTRIES     = 256;
   localparam int   CLK_PERIOD      = 10;
   localparam int   RANDOM_ITEMS    = 1250;
   localparam int   RSP_HOLD_CYCLES = 300;
   localparam int   TAIL_CYCLES     = 8;
   localparam int   LIMIT_NS        = 5_000_000;
   localparam logic MODE_STREAM     = 1'b0;
   localparam logic MODE_LOOKUP     = 1'b1;

   typedef struct packed {
      logic              mode;
      logic [BYTE_W-1:0] data_byte;
      logic              chunk_end;
   } stream_item_type;

   typedef struct packed {
      logic              mode;
      logic [BYTE_W-1:0] data_byte;
      logic              chunk_end;
      logic              has_literal;
      rgb_type           rgb;
   } directed_row_type;

   localparam directed_row_type DIRECTED_ROWS [28] = '{
      // grayscale ramp after reset; chunk_end means nothing on a lookup
      '{MODE_LOOKUP, 8'h00, 1'b0, 1'b1, 24'h000000},
      '{MODE_LOOKUP, 8'hFF, 1'b0, 1'b1, 24'hFFFFFF},
      '{MODE_LOOKUP, 8'h80, 1'b1, 1'b1, 24'h808080},
      // one triple with a lookup in the middle; top two bits of each byte drop
      '{MODE_STREAM, 8'h00, 1'b0, 1'b0, 24'h0},
      '{MODE_STREAM, 8'h3F, 1'b0, 1'b0, 24'h0},
      '{MODE_LOOKUP, 8'h00, 1'b0, 1'b1, 24'h000000},
      '{MODE_STREAM, 8'hC0, 1'b0, 1'b0, 24'h0},
      '{MODE_STREAM, 8'hFF, 1'b0, 1'b0, 24'h0},
      // skip two, then copy two from a source that wraps past the top
      '{MODE_STREAM, CMD_SKIP_BIT | 8'd1, 1'b0, 1'b0, 24'h0},
      '{MODE_STREAM, CMD_COPY_BIT | 8'd1, 1'b0, 1'b0, 24'h0},
      '{MODE_STREAM, 8'hFF, 1'b1, 1'b0, 24'h0},
      '{MODE_LOOKUP, 8'h04, 1'b0, 1'b0, 24'h0},
      // overlapping copy: each entry reads the one written just before
      '{MODE_STREAM, CMD_SKIP_BIT, 1'b0, 1'b0, 24'h0},
      '{MODE_STREAM, CMD_COPY_BIT | 8'd3, 1'b0, 1'b0, 24'h0},
      '{MODE_STREAM, 8'h00, 1'b1, 1'b0, 24'h0},
      '{MODE_LOOKUP, 8'h04, 1'b0, 1'b0, 24'h0},
      // partial triple at chunk end, then a copy command with no source
      '{MODE_STREAM, 8'h00, 1'b0, 1'b0, 24'h0},
      '{MODE_STREAM, 8'h15, 1'b0, 1'b0, 24'h0},
      '{MODE_STREAM, 8'h2A, 1'b1, 1'b0, 24'h0},
      '{MODE_STREAM, CMD_COPY_BIT | LEN_MASK, 1'b1, 1'b0, 24'h0},
      '{MODE_LOOKUP, 8'h00, 1'b0, 1'b0, 24'h0},
      // skips run past the end and saturate; the rest of the chunk is ignored
      '{MODE_STREAM, 8'hFF, 1'b0, 1'b0, 24'h0},
      '{MODE_STREAM, 8'hFF, 1'b0, 1'b0, 24'h0},
      '{MODE_STREAM, 8'hFF, 1'b0, 1'b0, 24'h0},
      '{MODE_STREAM, 8'h00, 1'b1, 1'b0, 24'h0},
      // longest copy
      '{MODE_STREAM, CMD_COPY_BIT | LEN_MASK, 1'b0, 1'b0, 24'h0},
      '{MODE_STREAM, 8'hC0, 1'b1, 1'b0, 24'h0},
      '{MODE_LOOKUP, 8'h3F, 1'b0, 1'b0, 24'h0}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   pdd_req_if req_chan ();
   pdd_rsp_if rsp_chan ();

   palette_delta_decoder_core #(
      .PALETTE_ENTRIES(PAL_ENTRIES)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // palette as the block should hold it
   rgb_type     pal_mem [PAL_ENTRIES];
   int          wr_pos     = 0;
   phase_type   phase      = PH_CMD;
   int          runs_left  = 0;
   logic [7:0]  src_idx    = '0;
   logic [PEND_W-1:0] held_rg = '0;

   rgb_type     rgb_expected [$];
   int unsigned mismatches    = 0;
   int unsigned items_taken   = 0;
   int          req_gap_pct   = 32;
   int          rsp_stall_pct = 32;
   logic        hold_req      = 1'b0;
   int          hold_left     = 0;

   initial begin
      for (int i = 0; i < PAL_ENTRIES; i++) pal_mem[i] = {3{8'(i)}};
   end

   function automatic stream_item_type make_item(input logic mode, input logic [7:0] data,
                                                 input logic last);
      stream_item_type it;
      it.mode      = mode;
      it.data_byte = data;
      it.chunk_end = last;
      return it;
   endfunction

   function automatic stream_item_type random_lookup();
      logic [7:0] idx;
      // low entries are the ones chunks rewrite most
      idx = $urandom_range(1) ? 8'($urandom_range(31)) : 8'($urandom);
      return make_item(MODE_LOOKUP, idx, 1'($urandom));
   endfunction

   function automatic void settle_position();
      if (wr_pos >= PAL_ENTRIES) begin
         wr_pos = PAL_ENTRIES;
         phase  = PH_FULL;
      end else if (runs_left == 0) begin
         phase = PH_CMD;
      end
   endfunction

   function automatic void decode_stream_byte(input logic [7:0] b);
      case (phase)
         PH_CMD: begin
            if ((b & CMD_SKIP_BIT) != 0) begin
               wr_pos    = wr_pos + int'(b & SKIP_MASK) + 1;
               runs_left = 0;
               settle_position();
            end else begin
               runs_left = int'(b & LEN_MASK) + 1;
               phase     = ((b & CMD_COPY_BIT) != 0) ? PH_SRC : PH_RED;
            end
         end
         PH_SRC: begin
            src_idx = b;
            // entries written earlier in the run are visible to later reads
            while (runs_left != 0 && wr_pos < PAL_ENTRIES) begin
               pal_mem[wr_pos] = pal_mem[src_idx];
               wr_pos++;
               src_idx++;
               runs_left--;
            end
            runs_left = 0;
            settle_position();
         end
         PH_RED: begin
            held_rg[15:8] = {b[5:0], 2'b00};
            phase         = PH_GRN;
         end
         PH_GRN: begin
            held_rg[7:0] = {b[5:0], 2'b00};
            phase        = PH_BLU;
         end
         PH_BLU: begin
            pal_mem[wr_pos] = {held_rg, b[5:0], 2'b00};
            wr_pos++;
            runs_left--;
            phase = PH_RED;
            settle_position();
         end
         default: ;
      endcase
   endfunction

   function automatic void apply_to_palette(input stream_item_type it, input logic has_literal,
                                            input rgb_type literal_rgb);
      if (it.mode == MODE_LOOKUP) begin
         rgb_expected.push_back(has_literal ? literal_rgb : pal_mem[it.data_byte]);
         items_taken++;
      end else begin
         if (phase != PH_FULL) items_taken++;
         decode_stream_byte(it.data_byte);
         if (it.chunk_end) begin
            wr_pos    = 0;
            phase     = PH_CMD;
            runs_left = 0;
         end
      end
   endfunction

   task automatic send_item(input stream_item_type it, input logic has_literal,
                            input rgb_type literal_rgb);
      while ($urandom_range(99) < req_gap_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.mode      <= it.mode;
      req_chan.data_byte <= it.data_byte;
      req_chan.chunk_end <= it.chunk_end;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      apply_to_palette(it, has_literal, literal_rgb);
   endtask

   // sender goes quiet until every pending lookup has come back
   task automatic drain_results();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (rgb_expected.size() != 0);
   endtask

   task automatic send_random_chunk(input int lookup_pct);
      stream_item_type bytes_q [$];
      stream_item_type it;
      int              n_cmds;
      int              kind;
      int              len;
      n_cmds = $urandom_range(1, 6);
      repeat (n_cmds) begin
         kind = $urandom_range(99);
         len  = ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(3);
         if (kind < 25) begin
            // mostly short skips, now and then one long enough to fill up
            len = ($urandom_range(7) == 0) ? $urandom_range(127) : $urandom_range(7);
            bytes_q.push_back(make_item(MODE_STREAM, CMD_SKIP_BIT | 8'(len), 1'b0));
         end else if (kind < 55) begin
            bytes_q.push_back(make_item(MODE_STREAM, CMD_COPY_BIT | 8'(len), 1'b0));
            bytes_q.push_back(make_item(MODE_STREAM, 8'($urandom), 1'b0));
         end else if (kind < 95) begin
            bytes_q.push_back(make_item(MODE_STREAM, 8'(len), 1'b0));
            repeat (3 * (len + 1))
               bytes_q.push_back(make_item(MODE_STREAM, 8'($urandom), 1'b0));
         end else begin
            bytes_q.push_back(make_item(MODE_STREAM, 8'($urandom), 1'b0));
         end
      end
      // some chunks end early, mid command
      if ($urandom_range(99) < 15) begin
         repeat ($urandom_range(bytes_q.size() - 1)) it = bytes_q.pop_back();
      end
      it = bytes_q.pop_back();
      it.chunk_end = 1'b1;
      bytes_q.push_back(it);
      foreach (bytes_q[i]) begin
         while ($urandom_range(99) < lookup_pct) send_item(random_lookup(), 1'b0, '0);
         send_item(bytes_q[i], 1'b0, '0);
      end
   endtask

   // result side: random stalls, one long hold-off on request
   initial begin
      rgb_type want;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) begin
            if (rgb_expected.size() == 0) begin
               $error("rgb: no lookup pending, got %02h %02h %02h",
                      rsp_chan.red, rsp_chan.green, rsp_chan.blue);
               mismatches++;
            end else begin
               want = rgb_expected.pop_front();
               if (rsp_chan.red !== want[23:16]) begin
                  $error("red: expected %02h, got %02h", want[23:16], rsp_chan.red);
                  mismatches++;
               end
               if (rsp_chan.green !== want[15:8]) begin
                  $error("green: expected %02h, got %02h", want[15:8], rsp_chan.green);
                  mismatches++;
               end
               if (rsp_chan.blue !== want[7:0]) begin
                  $error("blue: expected %02h, got %02h", want[7:0], rsp_chan.blue);
                  mismatches++;
               end
            end
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else if (hold_req) begin
            hold_req       = 1'b0;
            hold_left      = RSP_HOLD_CYCLES;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   initial begin
      int unsigned random_start;
      logic        quiet;
      req_chan.valid     = 1'b0;
      req_chan.mode      = MODE_STREAM;
      req_chan.data_byte = '0;
      req_chan.chunk_end = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_ROWS[i]) begin
         send_item(make_item(DIRECTED_ROWS[i].mode, DIRECTED_ROWS[i].data_byte,
                             DIRECTED_ROWS[i].chunk_end),
                   DIRECTED_ROWS[i].has_literal, DIRECTED_ROWS[i].rgb);
      end

      // back pressure: output blocked while the sender keeps pushing
      req_gap_pct = 0;
      hold_req    = 1'b1;
      repeat (40) begin
         send_item(make_item(1'($urandom), 8'($urandom), $urandom_range(7) == 0), 1'b0, '0);
      end
      drain_results();

      random_start = items_taken;
      while (items_taken - random_start < RANDOM_ITEMS) begin
         quiet = (items_taken - random_start >= 400) && (items_taken - random_start < 700);
         req_gap_pct   = quiet ? 0 : 32;
         rsp_stall_pct = quiet ? 0 : 32;
         send_random_chunk(30);
      end

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && rgb_expected.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #(LIMIT_NS);
      $display("end of test: mismatches");
      $finish;
   end

endmodule

@@ filelist.f @@
design/pdd_pkg.sv
design/pdd_if.sv
design/pdd_ram.sv
design/palette_delta_decoder_core.sv
sim/tb_palette_delta_decoder_core.sv
